// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PRIO_BITS   = 8;
	localparam int ID_BITS     = 16;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_POP    = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WORK,
		S_SEND
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // capture the incoming item
		logic exec;  // apply the captured operation to the cell chain
	} cmd_t;

endpackage

// ===== hw/rtl/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Cell chain holding the sorted entries, with the result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH,
	parameter int PRIO_BITS   = spq_pkg::PRIO_BITS,
	parameter int ID_BITS     = spq_pkg::ID_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spq_pkg::cmd_t          cmd,
	input  logic [1:0]             mode,
	input  logic [15:0]            process_id,
	input  logic [7:0]             prio_value,
	output logic [1:0]             status,
	output logic [15:0]            out_process_id,
	output logic [4:0]             entry_count,
	output logic                   queue_empty
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [PRIO_BITS-1:0] prio_q [QUEUE_DEPTH];
	logic [ID_BITS-1:0]   id_q   [QUEUE_DEPTH];
	logic [CW-1:0]        count_q;
	logic [1:0]           mode_q;
	logic [ID_BITS-1:0]   in_id_q;
	logic [PRIO_BITS-1:0] in_prio_q;

	// Per-cell decisions: every cell compares with the new item at once.
	logic [QUEUE_DEPTH-1:0] valid;
	logic [QUEUE_DEPTH-1:0] greater;   // valid cell with priority above the new one
	logic [QUEUE_DEPTH-1:0] prev_greater; // the cell in front is greater
	logic [QUEUE_DEPTH-1:0] prev_valid;   // the cell in front is valid, true at the head
	logic [QUEUE_DEPTH-1:0] match;     // valid cell whose id matches
	logic [QUEUE_DEPTH-1:0] after_hit; // cell lies after the first match
	logic [QUEUE_DEPTH-1:0] hit_at;
	logic                   any_hit;
	logic [ID_BITS-1:0]     hit_id;
	logic                   full;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			valid[i]   = CW'(i) < count_q;
			greater[i] = valid[i] && (prio_q[i] > in_prio_q);
			match[i]   = valid[i] && (id_q[i] == in_id_q);
		end
		after_hit[0]    = 1'b0;
		prev_greater[0] = 1'b0;
		prev_valid[0]   = 1'b1;
		for (int i = 1; i < QUEUE_DEPTH; i++) begin
			after_hit[i]    = after_hit[i-1] | match[i-1];
			prev_greater[i] = greater[i-1];
			prev_valid[i]   = valid[i-1];
		end
		hit_at  = match & ~after_hit;
		any_hit = |match;
		hit_id  = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (hit_at[i]) begin
				hit_id = id_q[i];
			end
		end
		full = count_q == CW'(QUEUE_DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= '0;
		end else if (cmd.load) begin
			mode_q <= mode;
		end else if (cmd.exec) begin
			case (mode_q)
				spq_pkg::MODE_INSERT: begin
					if (!full) count_q <= count_q + 1'b1;
				end
				spq_pkg::MODE_POP: begin
					if (count_q != '0) count_q <= count_q - 1'b1;
				end
				spq_pkg::MODE_REMOVE: begin
					if (any_hit) count_q <= count_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_id_q   <= ID_BITS'(process_id);
			in_prio_q <= PRIO_BITS'(prio_value);
		end
		if (cmd.exec) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				case (mode_q)
					spq_pkg::MODE_INSERT: begin
						if (!full) begin
							if (prev_greater[i]) begin
								prio_q[i] <= prio_q[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
								id_q[i]   <= id_q[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
							end else if (greater[i] || (!valid[i] && prev_valid[i])) begin
								// First greater cell, or the first free cell when none is greater.
								prio_q[i] <= in_prio_q;
								id_q[i]   <= in_id_q;
							end
						end
					end
					spq_pkg::MODE_POP, spq_pkg::MODE_REMOVE: begin
						if ((mode_q == spq_pkg::MODE_POP || any_hit)
								&& i + 1 < QUEUE_DEPTH
								&& (mode_q == spq_pkg::MODE_POP || hit_at[i] || after_hit[i])) begin
							prio_q[i] <= prio_q[(i + 1) % QUEUE_DEPTH];
							id_q[i]   <= id_q[(i + 1) % QUEUE_DEPTH];
						end
					end
					default: ;
				endcase
			end
			// Result for this item, built from the state before the update.
			status         <= spq_pkg::ST_OK;
			out_process_id <= '0;
			case (mode_q)
				spq_pkg::MODE_INSERT: begin
					if (full) status <= spq_pkg::ST_FULL;
					entry_count <= 5'(count_q + (full ? 1'b0 : 1'b1));
					queue_empty <= 1'b0;
				end
				spq_pkg::MODE_POP: begin
					if (count_q == '0) begin
						status      <= spq_pkg::ST_MISS;
						entry_count <= '0;
						queue_empty <= 1'b1;
					end else begin
						out_process_id <= 16'(id_q[0]);
						entry_count    <= 5'(count_q - 1'b1);
						queue_empty    <= count_q == CW'(1);
					end
				end
				spq_pkg::MODE_REMOVE: begin
					if (!any_hit) begin
						status      <= spq_pkg::ST_MISS;
						entry_count <= 5'(count_q);
						queue_empty <= count_q == '0;
					end else begin
						out_process_id <= 16'(hit_id);
						entry_count    <= 5'(count_q - 1'b1);
						queue_empty    <= count_q == CW'(1);
					end
				end
				default: begin
					entry_count <= 5'(count_q);
					queue_empty <= count_q == '0;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: capture an item, execute it, hold the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output spq_pkg::cmd_t cmd
);

	spq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			spq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = spq_pkg::S_WORK;
				end
			end
			spq_pkg::S_WORK: begin
				cmd.exec = 1'b1;
				state_d  = spq_pkg::S_SEND;
			end
			spq_pkg::S_SEND: begin
				out_valid = 1'b1;
				if (out_ready) state_d = spq_pkg::S_IDLE;
			end
			default: state_d = spq_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of process ids kept in ascending priority order.
// ----------------------------------------------------------------------------
// Usage: an item enters on in_valid/in_ready with mode, process_id and
// prio_value. Mode insert places the id behind all entries of equal or lower
// priority value, pop takes the head, remove takes the first matching id.
// Each item gives one result on out_valid/out_ready carrying status,
// out_process_id, entry_count and queue_empty.
// Sequence: the item is captured in S_IDLE, the cell chain updates in S_WORK,
// and the result is offered in S_SEND. Every cell compares against the
// captured item in parallel; the controller handles one item at a time.
// Reset clears the entry count and the controller; entry storage is not
// cleared, since only entries below the count are ever read.
// When the receiver stalls, the result is held unchanged and no new item is
// taken until it has been accepted.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH,
	parameter int PRIO_BITS   = spq_pkg::PRIO_BITS,
	parameter int ID_BITS     = spq_pkg::ID_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [15:0] process_id,
	input  logic [7:0]  prio_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] out_process_id,
	output logic [4:0]  entry_count,
	output logic        queue_empty
);

	spq_pkg::cmd_t cmd;

	// The controller sequences the handshakes.
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath holds the sorted cell chain and the result register.
	spq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PRIO_BITS   (PRIO_BITS),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.mode           (mode),
		.process_id     (process_id),
		.prio_value     (prio_value),
		.status         (status),
		.out_process_id (out_process_id),
		.entry_count    (entry_count),
		.queue_empty    (queue_empty)
	);

endmodule
